[sv/cspl_pkg.sv]
// Shared constants, register codes and the sequencer configuration type
// for the cardinal spline point stream. Depends on nothing.
package cspl_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int TENSION_W  = 9;
  localparam int SEGMENTS_W = 7;

  // Register reset values and the unit tension in Q.8.
  localparam int TENSION_RESET  = 256;
  localparam int SEGMENTS_RESET = 16;
  localparam int TENSION_ONE    = 256;

  // Curve parameter t is Q0.16; the per-sample step can reach 1.0.
  localparam int T_W    = 16;
  localparam int STEP_W = T_W + 1;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TENSION  = 2'd0,
    REG_SEGMENTS = 2'd1
  } cfg_reg_e;

  // Sample count and t increment handed from the front to the sample sequencer.
  typedef struct packed {
    logic [SEGMENTS_W-1:0] n;
    logic [STEP_W-1:0]     step;
    logic [SEGMENTS_W-1:0] rem;
    logic                  ready;
  } seq_cfg_t;

endpackage

[sv/cspl_fifo.sv]
// Short job queue between the coefficient front end and the sample back end.
// Generic width and depth; no package dependency.
module cspl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[sv/cspl_front.sv]
// Front end: configuration registers, t-step divider, control point window
// and Hermite coefficient setup. Uses cspl_pkg.
module cspl_front #(
  parameter int MAX_SEGMENTS = cspl_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH  = cspl_pkg::COORD_WIDTH_DEF,
  parameter int JOB_W        = 3 * (4 * COORD_WIDTH + 12)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cspl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cspl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]    pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]    pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]    pos_z_i,
  input  logic                             start_curve_i,
  output cspl_pkg::seq_cfg_t               seq_cfg_o,
  output logic [JOB_W-1:0]                 job_o,
  output logic                             job_push_o,
  input  logic                             job_full_i
);
  import cspl_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int CW     = W + 4;
  localparam int MW     = W + 2;
  localparam int PTW    = W + 11;
  localparam int AXIS_W = 3 * CW + W;
  localparam int CNT_W  = $clog2(STEP_W);

  localparam int N_RESET    = (SEGMENTS_RESET > MAX_SEGMENTS) ? MAX_SEGMENTS : SEGMENTS_RESET;
  localparam int STEP_RESET = (1 << T_W) / N_RESET;
  localparam int REM_RESET  = (1 << T_W) % N_RESET;

  typedef enum logic [1:0] {
    F_IDLE,
    F_TANG,
    F_COEF
  } front_state_e;

  front_state_e state_q;

  logic signed [W-1:0]  win_q [3][3];
  logic signed [W-1:0]  p3_q [3];
  logic signed [MW-1:0] m1_q [3];
  logic signed [MW-1:0] m2_q [3];
  logic signed [W-1:0]  pos [3];

  logic [TENSION_W-1:0]  scale_q;
  logic [SEGMENTS_W-1:0] n_q;
  logic                  div_busy_q;
  logic [CNT_W-1:0]      div_cnt_q;
  logic [SEGMENTS_W-1:0] div_rem_q;
  logic [STEP_W-1:0]     div_quo_q;

  logic                  cfg_we;
  logic                  seg_we;
  logic                  in_acc;
  logic [SEGMENTS_W-1:0] seg_clamped;
  logic [TENSION_W-1:0]  scale_new;
  logic [SEGMENTS_W:0]   div_trial;
  logic [SEGMENTS_W:0]   div_diff;
  logic                  div_ge;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign seg_we      = cfg_we && (cfg_index_i == REG_SEGMENTS);
  assign in_ready_o  = (state_q == F_IDLE) && !div_busy_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign job_push_o  = (state_q == F_COEF) && !job_full_i;

  assign seq_cfg_o.n     = n_q;
  assign seq_cfg_o.step  = div_quo_q;
  assign seq_cfg_o.rem   = div_rem_q;
  assign seq_cfg_o.ready = !div_busy_q;

  // Register value clamping: tension saturates at one, segments to 1..MAX.
  always_comb begin
    if (cfg_data_i > CFG_DATA_W'(TENSION_ONE)) begin
      scale_new = '0;
    end else begin
      scale_new = TENSION_W'(TENSION_ONE) - cfg_data_i[TENSION_W-1:0];
    end
    if (cfg_data_i[SEGMENTS_W-1:0] == '0) begin
      seg_clamped = SEGMENTS_W'(1);
    end else if (cfg_data_i[SEGMENTS_W-1:0] > SEGMENTS_W'(MAX_SEGMENTS)) begin
      seg_clamped = SEGMENTS_W'(MAX_SEGMENTS);
    end else begin
      seg_clamped = cfg_data_i[SEGMENTS_W-1:0];
    end
  end

  // One restoring step of 65536 / n; the dividend has only its top bit set.
  always_comb begin
    div_trial = {div_rem_q, (div_cnt_q == CNT_W'(STEP_W - 1))};
    div_ge    = (div_trial >= {1'b0, n_q});
    div_diff  = div_trial - {1'b0, n_q};
  end

  // Configuration registers and the bit-serial t-step divider.
  // A new segments write restarts the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= '0;
      n_q        <= SEGMENTS_W'(N_RESET);
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      div_rem_q  <= SEGMENTS_W'(REM_RESET);
      div_quo_q  <= STEP_W'(STEP_RESET);
    end else begin
      if (div_busy_q && !seg_we) begin
        div_rem_q <= div_ge ? div_diff[SEGMENTS_W-1:0] : div_trial[SEGMENTS_W-1:0];
        div_quo_q <= {div_quo_q[STEP_W-2:0], div_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          div_busy_q <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index_i)
          REG_TENSION: begin
            scale_q <= scale_new;
          end
          REG_SEGMENTS: begin
            n_q        <= seg_clamped;
            div_busy_q <= 1'b1;
            div_cnt_q  <= CNT_W'(STEP_W - 1);
            div_rem_q  <= '0;
            div_quo_q  <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sequencer state and the three-point window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[i][k] <= '0;
        end
      end
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_acc) begin
            if (start_curve_i) begin
              for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                  win_q[i][k] <= pos[k];
                end
              end
            end else begin
              state_q <= F_TANG;
            end
          end
        end
        F_TANG: begin
          state_q <= F_COEF;
        end
        F_COEF: begin
          if (job_push_o) begin
            for (int k = 0; k < 3; k++) begin
              win_q[0][k] <= win_q[1][k];
              win_q[1][k] <= win_q[2][k];
              win_q[2][k] <= p3_q[k];
            end
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  // Tangents: difference times scale, then a flooring shift by eight.
  logic signed [W:0]     d1 [3];
  logic signed [W:0]     d2 [3];
  logic signed [PTW-1:0] t1_prod [3];
  logic signed [PTW-1:0] t2_prod [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1[k]      = (W+1)'(win_q[2][k]) - (W+1)'(win_q[0][k]);
      d2[k]      = (W+1)'(p3_q[k]) - (W+1)'(win_q[1][k]);
      t1_prod[k] = d1[k] * $signed({1'b0, scale_q});
      t2_prod[k] = d2[k] * $signed({1'b0, scale_q});
    end
  end

  // Incoming point and tangent registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        p3_q[k] <= pos[k];
      end
    end
    if (state_q == F_TANG) begin
      for (int k = 0; k < 3; k++) begin
        m1_q[k] <= t1_prod[k][MW+7:8];
        m2_q[k] <= t2_prod[k][MW+7:8];
      end
    end
  end

  // Hermite coefficients per axis, packed as {a, b, c, d}.
  logic signed [CW-1:0] dd [3];
  logic signed [CW-1:0] ca [3];
  logic signed [CW-1:0] cb [3];
  logic signed [CW-1:0] cc [3];

  always_comb begin
    job_o = '0;
    for (int k = 0; k < 3; k++) begin
      dd[k] = CW'(win_q[2][k]) - CW'(win_q[1][k]);
      ca[k] = ((CW'(win_q[1][k]) - CW'(win_q[2][k])) <<< 1) + CW'(m1_q[k]) + CW'(m2_q[k]);
      cb[k] = dd[k] + (dd[k] <<< 1) - (CW'(m1_q[k]) <<< 1) - CW'(m2_q[k]);
      cc[k] = CW'(m1_q[k]);
      job_o[k*AXIS_W +: AXIS_W] = {ca[k], cb[k], cc[k], win_q[1][k]};
    end
  end

endmodule

[sv/cspl_back.sv]
// Back end: steps t across a segment and evaluates the cubic for all three
// axes in a five-stage pipeline with a registered output. Uses cspl_pkg.
module cspl_back #(
  parameter int COORD_WIDTH = cspl_pkg::COORD_WIDTH_DEF,
  parameter int JOB_W       = 3 * (4 * COORD_WIDTH + 12)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cspl_pkg::seq_cfg_t            seq_cfg_i,
  input  logic [JOB_W-1:0]              job_i,
  input  logic                          job_empty_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          last_sample_o
);
  import cspl_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int CW     = W + 4;
  localparam int AXIS_W = 3 * CW + W;
  localparam int PRW    = CW + T_W + 1;
  localparam int SW     = CW + 3;

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (W - 1)));

  // Sample sequencer.
  logic                  busy_q;
  logic [SEGMENTS_W-1:0] j_q;
  logic [STEP_W-1:0]     t_q;
  logic [SEGMENTS_W-1:0] r_q;
  logic [JOB_W-1:0]      cur_q;

  logic                  adv;
  logic                  issue;
  logic                  last_now;
  logic [SEGMENTS_W:0]   r_sum;
  logic [SEGMENTS_W:0]   r_wrap;
  logic                  wrap;

  // Pipeline registers.
  logic                  s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_valid_q;
  logic                  s1_last_q, s2_last_q, s3_last_q, s4_last_q, out_last_q;
  logic [T_W-1:0]        s1_t_q, s2_t_q, s3_t_q;
  logic [T_W-1:0]        s2_t2_q, s3_t2_q, s3_t3_q;
  logic [JOB_W-1:0]      s1_coef_q, s2_coef_q, s3_coef_q;
  logic [2*T_W-1:0]      sq_prod, cube_prod;

  logic signed [CW:0]    s4_pa_q [3];
  logic signed [CW:0]    s4_pb_q [3];
  logic signed [CW:0]    s4_pc_q [3];
  logic signed [W-1:0]   s4_d_q [3];
  logic signed [W-1:0]   out_q [3];

  logic signed [CW-1:0]  coef_a [3];
  logic signed [CW-1:0]  coef_b [3];
  logic signed [CW-1:0]  coef_c [3];
  logic signed [PRW-1:0] pa [3];
  logic signed [PRW-1:0] pb [3];
  logic signed [PRW-1:0] pc [3];
  logic signed [SW-1:0]  sum [3];
  logic signed [SW-1:0]  sat [3];

  // The pipeline moves whenever the output register is free or being drained.
  assign adv       = !out_valid_q || out_ready_i;
  assign issue     = busy_q && adv;
  assign last_now  = (j_q == seq_cfg_i.n - SEGMENTS_W'(1));
  assign job_pop_o = !job_empty_i && (!busy_q || (issue && last_now));

  // Next t: add the integer step and carry out of the remainder accumulator.
  assign r_sum  = {1'b0, r_q} + {1'b0, seq_cfg_i.rem};
  assign wrap   = (r_sum >= {1'b0, seq_cfg_i.n});
  assign r_wrap = r_sum - {1'b0, seq_cfg_i.n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      j_q    <= '0;
      t_q    <= '0;
      r_q    <= '0;
    end else begin
      if (job_pop_o) begin
        busy_q <= 1'b1;
        j_q    <= '0;
        t_q    <= '0;
        r_q    <= '0;
      end else if (issue) begin
        if (last_now) begin
          busy_q <= 1'b0;
        end else begin
          j_q <= j_q + 1'b1;
          t_q <= t_q + seq_cfg_i.step + STEP_W'(wrap);
          r_q <= wrap ? r_wrap[SEGMENTS_W-1:0] : r_sum[SEGMENTS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_q <= job_i;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= busy_q;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      out_valid_q <= s4_v_q;
    end
  end

  // Powers of t, one multiply per stage.
  assign sq_prod   = s1_t_q * s1_t_q;
  assign cube_prod = s2_t2_q * s2_t_q;

  // Coefficient products with flooring shifts, then sum and saturate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coef_a[k] = s3_coef_q[k*AXIS_W + W + 2*CW +: CW];
      coef_b[k] = s3_coef_q[k*AXIS_W + W + CW +: CW];
      coef_c[k] = s3_coef_q[k*AXIS_W + W +: CW];
      pa[k]     = coef_a[k] * $signed({1'b0, s3_t3_q});
      pb[k]     = coef_b[k] * $signed({1'b0, s3_t2_q});
      pc[k]     = coef_c[k] * $signed({1'b0, s3_t_q});
      sum[k]    = SW'(s4_pa_q[k]) + SW'(s4_pb_q[k]) + SW'(s4_pc_q[k]) + SW'(s4_d_q[k]);
      if (sum[k] > SAT_HI) begin
        sat[k] = SAT_HI;
      end else if (sum[k] < SAT_LO) begin
        sat[k] = SAT_LO;
      end else begin
        sat[k] = sum[k];
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_t_q     <= t_q[T_W-1:0];
      s1_last_q  <= last_now;
      s1_coef_q  <= cur_q;
      s2_t_q     <= s1_t_q;
      s2_t2_q    <= sq_prod[2*T_W-1:T_W];
      s2_last_q  <= s1_last_q;
      s2_coef_q  <= s1_coef_q;
      s3_t_q     <= s2_t_q;
      s3_t2_q    <= s2_t2_q;
      s3_t3_q    <= cube_prod[2*T_W-1:T_W];
      s3_last_q  <= s2_last_q;
      s3_coef_q  <= s2_coef_q;
      s4_last_q  <= s3_last_q;
      out_last_q <= s4_last_q;
      for (int k = 0; k < 3; k++) begin
        s4_pa_q[k] <= pa[k][PRW-1:T_W];
        s4_pb_q[k] <= pb[k][PRW-1:T_W];
        s4_pc_q[k] <= pc[k][PRW-1:T_W];
        s4_d_q[k]  <= s3_coef_q[k*AXIS_W +: W];
        out_q[k]   <= sat[k][W-1:0];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_q[0];
  assign out_y_o       = out_q[1];
  assign out_z_o       = out_q[2];
  assign last_sample_o = out_last_q;

endmodule

[sv/cardinal_spline_point_stream_top.sv]
// Top level of the cardinal spline point stream: front end, job queue and
// sample back end. Uses cspl_pkg, cspl_front, cspl_fifo and cspl_back.
//
// Usage. Control points enter on the in channel (valid/ready); a point with
// start_curve set loads the whole three-point window and yields no sample.
// Every other point yields "segments" samples of the curve between the two
// middle window points on the out channel, last_sample marking the final one.
// The configuration channel writes tension (index 0) and segments (index 1);
// it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this.
// Throughput: one sample per cycle while the receiver is ready and a job is
// queued. The front end takes each point through its tangent and coefficient
// steps before it accepts the next; the back end has a single t sequencer.
// A write to segments starts the bit-serial divider for the t step;
// in_ready stays low until it is done.
// Reset sets tension 256, segments 16 and clears the window to zeros.
// When out_ready is low with a sample waiting, the output register holds it and
// the whole back pipeline stalls; the queue then fills and in_ready drops.
module cardinal_spline_point_stream_top #(
  parameter int MAX_SEGMENTS = cspl_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_WIDTH  = cspl_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = cspl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cspl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cspl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]   pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]   pos_z_i,
  input  logic                            start_curve_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [COORD_WIDTH-1:0]   out_x_o,
  output logic signed [COORD_WIDTH-1:0]   out_y_o,
  output logic signed [COORD_WIDTH-1:0]   out_z_o,
  output logic                            last_sample_o
);
  import cspl_pkg::*;

  localparam int JOB_W = 3 * (4 * COORD_WIDTH + 12);

  seq_cfg_t         seq_cfg;
  logic [JOB_W-1:0] job_wdata, job_rdata;
  logic             job_push, job_pop, job_full, job_empty;

  // Window, configuration and coefficient setup.
  cspl_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_WIDTH  (COORD_WIDTH),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .start_curve_i (start_curve_i),
    .seq_cfg_o     (seq_cfg),
    .job_o         (job_wdata),
    .job_push_o    (job_push),
    .job_full_i    (job_full)
  );

  // Segment jobs waiting for the back end.
  cspl_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  // Sample generation and curve evaluation.
  cspl_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seq_cfg_i     (seq_cfg),
    .job_i         (job_rdata),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .last_sample_o (last_sample_o)
  );

`ifndef SYNTH
  // The front end never writes a job into a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  // The back end only takes a job that is present.
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");

  // No point is taken while the t step is still being divided out.
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seq_cfg.ready |-> !in_ready_o)
    else $error("point accepted while t step divider busy");
`endif

endmodule
